@@ rtl/faqb_pkg.sv @@
package faqb_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 8;
    localparam int ADDR_BITS   = 32;

    // Fixed width of the address fields on the channels
    localparam int FIELD_BITS  = 32;

    // Count runs 0..QUEUE_DEPTH inclusive
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef logic [ADDR_BITS-1:0] addr_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    // Per-slot control from the queue controller
    typedef struct packed {
        logic load;   // capture the pushed address
        logic shift;  // take the neighbor's address (head moves out)
    } slot_ctrl_t;

endpackage

@@ rtl/faqb_req_if.sv @@
interface faqb_req_if;
    logic        valid;
    logic        ready;
    logic        clear_request;
    logic        flush_refetch;
    logic        push_valid;
    logic [31:0] push_addr;
    logic        pop_request;

    modport source (
        output valid, clear_request, flush_refetch, push_valid, push_addr, pop_request,
        input  ready
    );
    modport sink (
        input  valid, clear_request, flush_refetch, push_valid, push_addr, pop_request,
        output ready
    );
endinterface

@@ rtl/faqb_rsp_if.sv @@
interface faqb_rsp_if;
    logic        valid;
    logic        ready;
    logic        pop_valid;
    logic [31:0] pop_addr;
    logic        almost_full_flag;
    logic        empty_flag;
    logic        overflow_flag;

    modport source (
        output valid, pop_valid, pop_addr, almost_full_flag, empty_flag, overflow_flag,
        input  ready
    );
    modport sink (
        input  valid, pop_valid, pop_addr, almost_full_flag, empty_flag, overflow_flag,
        output ready
    );
endinterface

@@ rtl/faqb_slot.sv @@
module faqb_slot
    import faqb_pkg::*;
(
    input  logic       clk,
    input  slot_ctrl_t ctrl,
    input  addr_t      load_addr,
    input  addr_t      neighbor_addr,
    output addr_t      addr
);

    addr_t addr_reg;
    addr_t addr_next;

    // A load wins over a shift: on a push with pop the tail slot takes the
    // new address directly instead of its (empty) neighbor.
    always_comb
    begin
        addr_next = addr_reg;
        if (ctrl.load)
        begin
            addr_next = load_addr;
        end
        else if (ctrl.shift)
        begin
            addr_next = neighbor_addr;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
    end

    assign addr = addr_reg;

endmodule

@@ rtl/fetch_address_queue_bypass_unit.sv @@
// Channel | Dir | Payload                                             | Accepted when
// req     | in  | clear_request flush_refetch push_valid push_addr   | valid && ready
//         |     | pop_request                                         |
// rsp     | out | pop_valid pop_addr almost_full_flag empty_flag      | valid && ready
//         |     | overflow_flag                                       |
//
// One request per cycle; its response appears in the cycle after acceptance.
// The queue state (slot row and count) is updated at the accepting edge.
// req.ready is high whenever the response register is empty or being drained,
// so a stalled rsp holds the request side; nothing is lost or duplicated.
// Reset clears the count and the response valid; slot contents are not reset.
module fetch_address_queue_bypass_unit
    import faqb_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    faqb_req_if.sink       req,
    faqb_rsp_if.source     rsp
);

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic req_fire;
    logic rsp_valid_reg;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;

    // ------------------------------------------------------------------
    // Queue control: effective count after a refetch flush, then push/pop
    // ------------------------------------------------------------------
    cnt_t  count_reg;
    cnt_t  count_next;
    cnt_t  cnt_eff;
    cnt_t  cnt_new;
    addr_t push_addr_q;
    addr_t head_addr;
    logic  full;
    logic  overflow;
    logic  accept;
    logic  served;
    logic  do_clear;

    assign do_clear    = req.clear_request;
    assign push_addr_q = ADDR_BITS'(req.push_addr);
    assign cnt_eff     = req.flush_refetch ? '0 : count_reg;
    assign full        = (cnt_eff == CNT_BITS'(QUEUE_DEPTH));
    assign overflow    = req.push_valid && full;
    assign accept      = req.push_valid && !full;
    // Served from the head, or by bypass of this request's push on an empty queue
    assign served      = req.pop_request && ((cnt_eff != '0) || accept);

    always_comb
    begin
        cnt_new = cnt_eff;
        if (accept && !served)
        begin
            cnt_new = cnt_eff + CNT_BITS'(1);
        end
        else if (served && !accept)
        begin
            cnt_new = cnt_eff - CNT_BITS'(1);
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (req_fire)
        begin
            count_next = do_clear ? '0 : cnt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // ------------------------------------------------------------------
    // Slot row: slot 0 is the head, each slot takes its upper neighbor on pop
    // ------------------------------------------------------------------
    addr_t      slot_addr [QUEUE_DEPTH];
    slot_ctrl_t slot_ctrl [QUEUE_DEPTH];

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_slot
        addr_t nbr;

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign nbr = slot_addr[i];
        end
        else
        begin : g_mid
            assign nbr = slot_addr[i+1];
        end

        // Push lands at the tail; when the same request pops, the row shifts
        // down so the tail position is one lower. Bypass (empty, push+pop)
        // matches no slot for the load; the row still shifts, over empty slots.
        always_comb
        begin
            slot_ctrl[i].shift = req_fire && !do_clear && served;
            slot_ctrl[i].load  = req_fire && !do_clear && accept &&
                                 (served ? (CNT_BITS'(i + 1) == cnt_eff)
                                         : (CNT_BITS'(i) == cnt_eff));
        end

        faqb_slot u_slot (
            .clk           (clk),
            .ctrl          (slot_ctrl[i]),
            .load_addr     (push_addr_q),
            .neighbor_addr (nbr),
            .addr          (slot_addr[i])
        );
    end

    assign head_addr = (cnt_eff != '0) ? slot_addr[0] : push_addr_q;

    // ------------------------------------------------------------------
    // Response register
    // ------------------------------------------------------------------
    logic                  rsp_valid_next;
    logic                  pop_valid_reg;
    logic                  pop_valid_next;
    logic [FIELD_BITS-1:0] pop_addr_reg;
    logic [FIELD_BITS-1:0] pop_addr_next;
    logic                  almost_full_reg;
    logic                  almost_full_next;
    logic                  empty_reg;
    logic                  empty_next;
    logic                  overflow_reg;
    logic                  overflow_next;

    always_comb
    begin
        rsp_valid_next   = rsp_valid_reg;
        pop_valid_next   = pop_valid_reg;
        pop_addr_next    = pop_addr_reg;
        almost_full_next = almost_full_reg;
        empty_next       = empty_reg;
        overflow_next    = overflow_reg;
        if (req_fire)
        begin
            rsp_valid_next = 1'b1;
            if (do_clear)
            begin
                pop_valid_next   = 1'b0;
                pop_addr_next    = '0;
                almost_full_next = 1'b0;
                empty_next       = 1'b1;
                overflow_next    = 1'b0;
            end
            else
            begin
                pop_valid_next   = served;
                pop_addr_next    = served ? FIELD_BITS'(head_addr) : '0;
                almost_full_next = (cnt_new >= CNT_BITS'(QUEUE_DEPTH - 1));
                empty_next       = (cnt_new == '0);
                overflow_next    = overflow;
            end
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_valid_reg   <= pop_valid_next;
        pop_addr_reg    <= pop_addr_next;
        almost_full_reg <= almost_full_next;
        empty_reg       <= empty_next;
        overflow_reg    <= overflow_next;
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.pop_valid        = pop_valid_reg;
    assign rsp.pop_addr         = pop_addr_reg;
    assign rsp.almost_full_flag = almost_full_reg;
    assign rsp.empty_flag       = empty_reg;
    assign rsp.overflow_flag    = overflow_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_clear_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && req.clear_request) |=>
            (rsp.valid && rsp.empty_flag && !rsp.pop_valid && count_reg == '0))
        else $error("clear request did not empty the queue");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && !req.clear_request && !req.flush_refetch && req.push_valid &&
         count_reg == CNT_BITS'(QUEUE_DEPTH)) |=>
            (rsp.overflow_flag && count_reg == CNT_BITS'(QUEUE_DEPTH) - CNT_BITS'(rsp.pop_valid)))
        else $error("push into full queue not dropped");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        $past(req_fire) |-> (rsp.empty_flag == (count_reg == '0)))
        else $error("empty flag disagrees with count");

endmodule

@@ tb/fetch_address_queue_bypass_unit_test.sv @@
`timescale 1ns / 1ps

module fetch_address_queue_bypass_unit_test;
    import faqb_pkg::*;

    localparam int  CLK_HALF      = 6;
    localparam int  RESET_CYCLES  = 4;
    localparam int  RANDOM_ITEMS  = 1275;
    localparam int  QUIET_TAIL    = 150;     // last random requests run with no gaps
    localparam int  HOLD_AT_ITEM  = 400;     // where the long response hold-off starts
    localparam int  HOLD_CYCLES   = 120;
    localparam int  SEGMENT_ITEMS = 40;      // push/pop mix changes per segment
    localparam int  DRAIN_CYCLES  = 8;
    localparam int  CYCLE_LIMIT   = 400000;

    // One request on the req channel
    typedef struct packed {
        logic                  clear_request;
        logic                  flush_refetch;
        logic                  push_valid;
        logic [FIELD_BITS-1:0] push_addr;
        logic                  pop_request;
    } fetch_req_t;

    // One response on the rsp channel
    typedef struct packed {
        logic                  pop_valid;
        logic [FIELD_BITS-1:0] pop_addr;
        logic                  almost_full_flag;
        logic                  empty_flag;
        logic                  overflow_flag;
    } pop_rsp_t;

    // Shadow copy of the address queue plus the responses still owed by the block.
    class pop_scoreboard;
        addr_t    shadow_slots[$];
        pop_rsp_t owed_rsp[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        // Apply one accepted request to the shadow queue and queue its response.
        function void note_request(fetch_req_t r);
            pop_rsp_t e;
            logic     taken;
            logic     served;
            e = '0;
            if (r.clear_request)
            begin
                // clear wins over everything else in the same request
                shadow_slots.delete();
                e.empty_flag = 1'b1;
            end
            else
            begin
                if (r.flush_refetch)
                    shadow_slots.delete();
                e.overflow_flag = r.push_valid && (shadow_slots.size() >= QUEUE_DEPTH);
                taken  = r.push_valid && !e.overflow_flag;
                served = r.pop_request && (shadow_slots.size() > 0 || taken);
                // push before pop: on an empty queue the pushed address comes
                // straight back out, which is the bypass
                if (taken)
                    shadow_slots.push_back(addr_t'(r.push_addr));
                if (served)
                begin
                    e.pop_valid = 1'b1;
                    e.pop_addr  = FIELD_BITS'(shadow_slots.pop_front());
                end
                e.almost_full_flag = (shadow_slots.size() + 1 >= QUEUE_DEPTH);
                e.empty_flag       = (shadow_slots.size() == 0);
            end
            owed_rsp.push_back(e);
        endfunction

        function void check_response(pop_rsp_t got);
            pop_rsp_t e;
            if (owed_rsp.size() == 0)
            begin
                $error("response with none outstanding: pop_valid %0b pop_addr %h",
                       got.pop_valid, got.pop_addr);
                mismatches++;
                return;
            end
            e = owed_rsp.pop_front();
            if (got.pop_valid !== e.pop_valid)
            begin
                $error("pop_valid: expected %0b actual %0b", e.pop_valid, got.pop_valid);
                mismatches++;
            end
            if (got.pop_addr !== e.pop_addr)
            begin
                $error("pop_addr: expected %h actual %h", e.pop_addr, got.pop_addr);
                mismatches++;
            end
            if (got.almost_full_flag !== e.almost_full_flag)
            begin
                $error("almost_full_flag: expected %0b actual %0b",
                       e.almost_full_flag, got.almost_full_flag);
                mismatches++;
            end
            if (got.empty_flag !== e.empty_flag)
            begin
                $error("empty_flag: expected %0b actual %0b", e.empty_flag, got.empty_flag);
                mismatches++;
            end
            if (got.overflow_flag !== e.overflow_flag)
            begin
                $error("overflow_flag: expected %0b actual %0b",
                       e.overflow_flag, got.overflow_flag);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    faqb_req_if req_ch ();
    faqb_rsp_if rsp_ch ();

    fetch_address_queue_bypass_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    pop_scoreboard sb = new();

    bit quiet;          // set for the tail of the run: no gaps on either side
    bit hold_pending;   // asks the response side for one long hold-off
    bit sender_gaps;    // per-segment switch so some stretches run back to back
    int cycle_count;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("** fetch_address_queue_bypass_unit: FAILED **");
            $finish;
        end
    end

    // Monitor: both channels sampled at the edge, before this edge's updates land.
    // The response for a request is checked first; it always belongs to an
    // earlier request, so ordering within the edge does not matter.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response('{rsp_ch.pop_valid, rsp_ch.pop_addr,
                                    rsp_ch.almost_full_flag, rsp_ch.empty_flag,
                                    rsp_ch.overflow_flag});
            if (req_ch.valid && req_ch.ready)
                sb.note_request('{req_ch.clear_request, req_ch.flush_refetch,
                                  req_ch.push_valid, req_ch.push_addr,
                                  req_ch.pop_request});
        end
    end

    // Response side: random stall bursts, one long hold-off on request, and
    // occasional long runs of ready so back-to-back traffic gets exercised.
    initial
    begin
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_pending)
            begin
                // response register fills up, req.ready must drop
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_pending = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
                repeat (60) @(posedge clk);
            else
                repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    function automatic fetch_req_t make_req(logic clr, logic flush, logic push,
                                            logic [FIELD_BITS-1:0] addr, logic pop);
        return '{clr, flush, push, addr, pop};
    endfunction

    // Hold the request until the edge where it is taken.
    task automatic send_request(input fetch_req_t r);
        req_ch.valid         <= 1'b1;
        req_ch.clear_request <= r.clear_request;
        req_ch.flush_refetch <= r.flush_refetch;
        req_ch.push_valid    <= r.push_valid;
        req_ch.push_addr     <= r.push_addr;
        req_ch.pop_request   <= r.pop_request;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // Optional gap after an accepted request.
    task automatic sender_gap();
        if (sender_gaps && !quiet && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic run_directed();
        fetch_req_t seq[$];
        // pop on an empty queue with no push: not served
        seq.push_back(make_req(1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b1));
        // push and pop on an empty queue: bypass
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1));
        // fill to depth, almost-full on the way
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'h0000_0000, 1'b0));
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0));
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'hAAAA_AAAA, 1'b0));
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'h5555_5555, 1'b0));
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'h0000_0001, 1'b0));
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'h8000_0000, 1'b0));
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'h1234_5678, 1'b0));
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b0));
        // push into a full queue: dropped, flagged
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'hDEAD_BEEF, 1'b0));
        // push into full with pop: push dropped, head still served
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'hCAFE_F00D, 1'b1));
        seq.push_back(make_req(1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b1));
        // refetch with push and pop: queue emptied, pushed address bypasses
        seq.push_back(make_req(1'b0, 1'b1, 1'b1, 32'h0BAD_F00D, 1'b1));
        seq.push_back(make_req(1'b0, 1'b1, 1'b1, 32'h0000_1000, 1'b0));
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'h0000_2000, 1'b0));
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'h0000_3000, 1'b0));
        // refetch with pop only: emptied first, so nothing to serve
        seq.push_back(make_req(1'b0, 1'b1, 1'b0, 32'h0000_0000, 1'b1));
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'h0000_4000, 1'b0));
        // clear with every other bit set: suppresses push and pop
        seq.push_back(make_req(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1));
        seq.push_back(make_req(1'b0, 1'b0, 1'b0, 32'h0000_0000, 1'b1));
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'h0F0F_0F0F, 1'b0));
        seq.push_back(make_req(1'b0, 1'b0, 1'b1, 32'hF0F0_F0F0, 1'b0));
        seq.push_back(make_req(1'b1, 1'b0, 1'b0, 32'h0000_0000, 1'b0));
        seq.push_back(make_req(1'b0, 1'b1, 1'b0, 32'h0000_0000, 1'b0));
        foreach (seq[i])
        begin
            send_request(seq[i]);
            sender_gap();
        end
    endtask

    // Mostly push/pop traffic with a mix that drifts per segment so the queue
    // swings between empty and full; rare refetch/clear; some raw noise.
    task automatic run_random();
        fetch_req_t r;
        int         push_pct;
        int         pop_pct;
        push_pct = 50;
        pop_pct  = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % SEGMENT_ITEMS == 0)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        push_pct = 90;
                        pop_pct  = 20;
                    end
                    1:
                    begin
                        push_pct = 20;
                        pop_pct  = 90;
                    end
                    2:
                    begin
                        push_pct = 60;
                        pop_pct  = 60;
                    end
                    default:
                    begin
                        push_pct = 100;
                        pop_pct  = 10;
                    end
                endcase
                sender_gaps = ($urandom_range(0, 9) >= 3);
            end
            if (n == HOLD_AT_ITEM)
                hold_pending = 1'b1;
            if (n == RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            if ($urandom_range(0, 19) == 0)
                r = make_req(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), $urandom(),
                             1'($urandom_range(0, 1)));
            else
                r = make_req($urandom_range(0, 59) == 0, $urandom_range(0, 34) == 0,
                             $urandom_range(0, 99) < push_pct, $urandom(),
                             $urandom_range(0, 99) < pop_pct);
            send_request(r);
            sender_gap();
        end
        req_ch.valid <= 1'b0;
    endtask

    initial
    begin
        quiet        = 1'b0;
        hold_pending = 1'b0;
        sender_gaps  = 1'b1;
        cycle_count  = 0;
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.clear_request <= 1'b0;
        req_ch.flush_refetch <= 1'b0;
        req_ch.push_valid    <= 1'b0;
        req_ch.push_addr     <= '0;
        req_ch.pop_request   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();

        // let every owed response come back, then idle before the verdict
        while (sb.owed_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("** fetch_address_queue_bypass_unit: PASSED **");
        else
            $display("** fetch_address_queue_bypass_unit: FAILED **");
        $finish;
    end

endmodule
